/* design/msps_pkg.sv */
// ----------------------------------------------------------------------------
// msps_pkg : shared types and constants of the servo pulse sequencer
// Request structures, command codes, slot layout and the fixed servo remap.
// ----------------------------------------------------------------------------
package msps_pkg;

    // slot layout
    localparam int NUM_SLOTS  = 21;
    localparam int SLOT_W     = 5;
    localparam int NUM_GROUPS = 3;
    localparam int IDX_W      = 4;

    // width conversion: factor 1.8432 held with 14 fraction bits
    localparam int        FRAC_BITS = 14;
    localparam int        COEF_W    = 15;
    localparam int        WIDTH_W   = 12;
    localparam int        MOP_W     = COEF_W + WIDTH_W - 1;
    localparam int        ACC_W     = 31;
    localparam logic [COEF_W-1:0] COEF_Q14 = 15'd30199;
    localparam logic [ACC_W-1:0]  ACC_ONE  = 31'h4000_0000;

    // reset values
    localparam logic [15:0] SLOT_RESET       = 16'hF533;
    localparam logic [15:0] FRAME_BASE_RESET = 16'd28672;
    localparam logic [15:0] FILL_RESET_G0    = 16'hC666;
    localparam logic [15:0] FILL_RESET_G1    = 16'hC666;
    localparam logic [15:0] FILL_RESET_G2    = 16'hA600;

    // command codes
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_FILL = 2'd2;

    // group codes
    localparam logic [1:0] GRP_0 = 2'd0;
    localparam logic [1:0] GRP_1 = 2'd1;
    localparam logic [1:0] GRP_2 = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  group;
        logic [4:0]  servo;
        logic [11:0] width_us;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  out_group;
        logic [7:0]  pin_mask;
        logic [15:0] reload;
    } t_out_req;

    // control of the shared subtract unit
    typedef struct packed {
        logic             load;
        logic             sub;
        logic [ACC_W-1:0] load_val;
        logic [ACC_W-1:0] operand;
    } t_sub_ctrl;

    // write port of the slot table
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        logic [15:0]       data;
    } t_slot_wr;

    // software servo number to slot
    function automatic logic [SLOT_W-1:0] slot_of_servo(input logic [4:0] servo);
        logic [SLOT_W-1:0] s;
        case (servo)
            5'd8:    s = 5'd20;
            5'd9:    s = 5'd8;
            5'd10:   s = 5'd9;
            5'd11:   s = 5'd10;
            5'd12:   s = 5'd11;
            5'd13:   s = 5'd12;
            5'd14:   s = 5'd13;
            5'd15:   s = 5'd14;
            5'd16:   s = 5'd15;
            5'd17:   s = 5'd19;
            5'd18:   s = 5'd18;
            5'd19:   s = 5'd17;
            5'd20:   s = 5'd16;
            default: s = servo;
        endcase
        return s;
    endfunction

    function automatic logic [SLOT_W-1:0] group_first(input logic [1:0] g);
        logic [SLOT_W-1:0] f;
        case (g)
            GRP_1:   f = 5'd8;
            GRP_2:   f = 5'd16;
            default: f = 5'd0;
        endcase
        return f;
    endfunction

    function automatic logic [IDX_W-1:0] group_size(input logic [1:0] g);
        logic [IDX_W-1:0] n;
        case (g)
            GRP_2:   n = 4'd5;
            default: n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

/* design/msps_sub_unit.sv */
// ----------------------------------------------------------------------------
// msps_sub_unit : shared accumulate-subtract unit
// One accumulator and one subtractor, used for the shift-subtract width
// conversion and for the running frame-fill sums.
// ----------------------------------------------------------------------------
module msps_sub_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  msps_pkg::t_sub_ctrl           i_ctrl,
    output logic [msps_pkg::ACC_W-1:0]    o_acc
);

    logic [msps_pkg::ACC_W-1:0] r_acc;
    logic [msps_pkg::ACC_W-1:0] n_acc;

    // load, subtract or hold
    always_comb begin
        n_acc = r_acc;
        if (i_ctrl.load) begin
            n_acc = i_ctrl.load_val;
        end else if (i_ctrl.sub) begin
            n_acc = r_acc - i_ctrl.operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

/* design/msps_slot_store.sv */
// ----------------------------------------------------------------------------
// msps_slot_store : servo slot reload table
// 21 timer reload values, one write port and one read port.
// ----------------------------------------------------------------------------
module msps_slot_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  msps_pkg::t_slot_wr             i_wr,
    input  logic [msps_pkg::SLOT_W-1:0]    i_rd_addr,
    output logic [15:0]                    o_rd_data
);

    logic [15:0] r_tab [msps_pkg::NUM_SLOTS];

    // table write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msps_pkg::NUM_SLOTS; i++) begin
                r_tab[i] <= msps_pkg::SLOT_RESET;
            end
        end else if (i_wr.we) begin
            r_tab[i_wr.addr] <= i_wr.data;
        end
    end

    // read, out of range addresses give the reset value
    always_comb begin
        if (i_rd_addr < msps_pkg::SLOT_W'(msps_pkg::NUM_SLOTS)) begin
            o_rd_data = r_tab[i_rd_addr];
        end else begin
            o_rd_data = msps_pkg::SLOT_RESET;
        end
    end

endmodule

/* design/multiplexed_servo_pulse_sequencer.sv */
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_sequencer : three-group multiplexed servo pulse timing
// Tick requests return the group's one-hot pin mask, empty for the fill slot,
// and next timer reload in the cycle after they are taken. The result sits in
// an output register: a following request is taken in the cycle the result
// leaves, and the input stalls while a result is held back by the receiver.
// A set request converts microseconds to a reload by shift and subtract on
// the shared subtractor, one width bit per cycle, then writes its slot. A fill
// request walks the slot table through the same subtractor, one slot per cycle
// with a store step after each group. Both stall the input until done.
// frame_base may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  msps_pkg::t_in_req   i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output msps_pkg::t_out_req  o_out_req,
    input  logic                i_cfg_we,
    input  logic [15:0]         i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_WR   = 5'b00100,
        S_FILL = 5'b01000,
        S_FST  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [15:0]                     r_frame_base;
    logic [15:0]                     r_fill [msps_pkg::NUM_GROUPS];
    logic [msps_pkg::IDX_W-1:0]      r_idx  [msps_pkg::NUM_GROUPS];
    logic [msps_pkg::IDX_W-1:0]      r_cnt, n_cnt;
    logic [1:0]                      r_grp, n_grp;
    logic [msps_pkg::WIDTH_W-1:0]    r_w, n_w;
    logic [msps_pkg::MOP_W-1:0]      r_mop, n_mop;
    logic [msps_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic                            r_out_valid, n_out_valid;
    msps_pkg::t_out_req              r_out, n_out;

    logic                            in_acc;
    logic                            tick_acc;
    logic [msps_pkg::IDX_W-1:0]      tick_idx;
    logic [15:0]                     tick_fill;
    logic [msps_pkg::IDX_W-1:0]      tick_size;
    logic                            tick_is_fill;
    logic [msps_pkg::SLOT_W-1:0]     rd_addr;
    logic [15:0]                     rd_data;
    logic [msps_pkg::ACC_W-1:0]      acc;
    msps_pkg::t_sub_ctrl             sub_ctrl;
    msps_pkg::t_slot_wr              slot_wr;

    // handshake
    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign tick_acc    = in_acc && (i_in_req.cmd == msps_pkg::CMD_TICK)
                         && (i_in_req.group != 2'd3);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // current index and fill reload of the ticked group
    always_comb begin
        case (i_in_req.group)
            msps_pkg::GRP_1: begin
                tick_idx  = r_idx[1];
                tick_fill = r_fill[1];
            end
            msps_pkg::GRP_2: begin
                tick_idx  = r_idx[2];
                tick_fill = r_fill[2];
            end
            default: begin
                tick_idx  = r_idx[0];
                tick_fill = r_fill[0];
            end
        endcase
    end

    assign tick_size    = msps_pkg::group_size(i_in_req.group);
    assign tick_is_fill = (tick_idx >= tick_size);

    // slot table read address, tick in idle, walk during fill
    always_comb begin
        if (r_state == S_FILL) begin
            rd_addr = msps_pkg::group_first(r_grp) + msps_pkg::SLOT_W'(r_cnt);
        end else begin
            rd_addr = msps_pkg::group_first(i_in_req.group)
                      + msps_pkg::SLOT_W'(tick_idx);
        end
    end

    msps_slot_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (slot_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    msps_sub_unit u_sub (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sub_ctrl),
        .o_acc   (acc)
    );

    // sequencer
    always_comb begin
        n_state           = r_state;
        n_cnt             = r_cnt;
        n_grp             = r_grp;
        n_w               = r_w;
        n_mop             = r_mop;
        n_slot            = r_slot;
        sub_ctrl.load     = 1'b0;
        sub_ctrl.sub      = 1'b0;
        sub_ctrl.load_val = msps_pkg::ACC_W'(r_frame_base);
        sub_ctrl.operand  = msps_pkg::ACC_W'(r_mop);
        slot_wr.we        = 1'b0;
        slot_wr.addr      = r_slot;
        slot_wr.data      = acc[msps_pkg::FRAC_BITS +: 16];
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_req.cmd)
                        msps_pkg::CMD_SET: begin
                            if (i_in_req.servo < 5'(msps_pkg::NUM_SLOTS)) begin
                                n_state           = S_MUL;
                                n_cnt             = '0;
                                n_w               = i_in_req.width_us;
                                n_mop             = msps_pkg::MOP_W'(msps_pkg::COEF_Q14);
                                n_slot            = msps_pkg::slot_of_servo(i_in_req.servo);
                                sub_ctrl.load     = 1'b1;
                                sub_ctrl.load_val = msps_pkg::ACC_ONE;
                            end
                        end
                        msps_pkg::CMD_FILL: begin
                            n_state       = S_FILL;
                            n_cnt         = '0;
                            n_grp         = msps_pkg::GRP_0;
                            sub_ctrl.load = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_MUL: begin
                // one width bit per cycle
                sub_ctrl.sub = r_w[0];
                n_w          = r_w >> 1;
                n_mop        = r_mop << 1;
                n_cnt        = r_cnt + 4'd1;
                if (r_cnt == msps_pkg::IDX_W'(msps_pkg::WIDTH_W - 1)) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                slot_wr.we = 1'b1;
                n_state    = S_IDLE;
            end
            S_FILL: begin
                // 65536 minus slot is minus slot modulo 2^16
                sub_ctrl.sub     = 1'b1;
                sub_ctrl.operand = msps_pkg::ACC_W'(rd_data);
                n_cnt            = r_cnt + 4'd1;
                if (r_cnt == msps_pkg::group_size(r_grp) - 4'd1) begin
                    n_state = S_FST;
                end
            end
            S_FST: begin
                n_cnt         = '0;
                sub_ctrl.load = 1'b1;
                if (r_grp == msps_pkg::GRP_2) begin
                    n_state = S_IDLE;
                end else begin
                    n_grp   = r_grp + 2'd1;
                    n_state = S_FILL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        if (tick_acc) begin
            n_out_valid     = 1'b1;
            n_out.out_group = i_in_req.group;
            if (tick_is_fill) begin
                n_out.pin_mask = '0;
                n_out.reload   = tick_fill;
            end else begin
                n_out.pin_mask = 8'(1) << tick_idx[2:0];
                n_out.reload   = rd_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_grp       <= msps_pkg::GRP_0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_grp       <= n_grp;
            r_out_valid <= n_out_valid;
        end
    end

    // working registers without reset
    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_mop  <= n_mop;
        r_slot <= n_slot;
        r_out  <= n_out;
    end

    // frame base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= msps_pkg::FRAME_BASE_RESET;
        end else if (i_cfg_we) begin
            r_frame_base <= i_cfg_data;
        end
    end

    // fill reloads, stored at the end of each group walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill[0] <= msps_pkg::FILL_RESET_G0;
            r_fill[1] <= msps_pkg::FILL_RESET_G1;
            r_fill[2] <= msps_pkg::FILL_RESET_G2;
        end else if (r_state == S_FST) begin
            r_fill[r_grp] <= acc[15:0];
        end
    end

    // per-group index, wraps after the fill interval
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < msps_pkg::NUM_GROUPS; g++) begin
                r_idx[g] <= '0;
            end
        end else if (tick_acc) begin
            r_idx[i_in_req.group] <= tick_is_fill ? '0 : tick_idx + 4'd1;
        end
    end

`ifndef SYNTH
    // a valid tick always yields a result next cycle
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> o_out_valid)
        else $error("tick request gave no result");

    // group indexes stay within their group plus the fill slot
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx[0] <= 4'd8) && (r_idx[1] <= 4'd8) && (r_idx[2] <= 4'd5))
        else $error("group index out of range");

    // the multiply walk ends on its last width bit
    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_cnt < msps_pkg::IDX_W'(msps_pkg::WIDTH_W)))
        else $error("width conversion overran");

    // each fill walk covers exactly the slots of its group
    a_fill_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FST) |-> (r_cnt == msps_pkg::group_size(r_grp)))
        else $error("fill walk length wrong");
`endif

endmodule
